>>> design/thermistor_adc_to_temperature_unit_macros.svh
// Assertion macros shared by the thermistor readout design.
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_UNIT_MACROS_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define NTC_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("thermistor unit assertion failed");
// Next-cycle implication, disabled during reset.
`define NTC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("thermistor unit assertion failed");
`else
`define NTC_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define NTC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> design/ntc_pkg.sv
package ntc_pkg;

    // Logarithm format: integer part, then this many fraction bits.
    localparam int LOG_FRAC_BITS = 24;
    // Normalize stage plus one squaring stage per fraction bit.
    localparam int LOG_LAT = LOG_FRAC_BITS + 1;
    localparam int MANT_W = 31;

    // ln 2 in Q.30.
    localparam int LN2_W = 30;
    localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;
    localparam int ROUND_SHIFT = 14;

    // Field widths.
    localparam int CODE_OUT_W = 10;
    localparam int TEMP_W = 21;
    localparam int STATUS_W = 2;
    localparam int CMD_W = 8;
    localparam int BETA_W = 16;
    localparam int NOM_W = 15;
    localparam int CHAN_W = 3;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_BETA = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOMINAL = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SINGLE = 8'd3;

    // Reset values of the registers.
    localparam logic [BETA_W-1:0] BETA_RESET = 16'd3950;
    localparam logic [NOM_W-1:0] NOM_RESET = 15'd2500;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 3'd1;
    localparam logic SINGLE_RESET = 1'b1;

    // Nominal inverse temperature: (100 << 40 + D/2) / D with D in centi-kelvin.
    localparam int NOM_DEN_W = 16;
    localparam int INV0_Q_W = 34;
    localparam int INV0_NUM_W = INV0_Q_W + NOM_DEN_W;
    localparam logic [INV0_NUM_W-1:0] INV0_NUMER = 50'd100 << 40;
    localparam logic signed [NOM_DEN_W-1:0] KELVIN_CENTI = 16'sd27315;

    // Final division (1000 << 40 + inv/2) / inv.
    localparam int TEMP_Q_W = 21;
    localparam logic [49:0] TEMP_NUMER = 50'd1000 << 40;
    localparam logic [TEMP_Q_W-1:0] Q_LIMIT = 21'd1273150;
    localparam logic [TEMP_Q_W-1:0] KELVIN_MILLI = 21'd273150;
    localparam logic [TEMP_W-1:0] TEMP_MAX = 21'd1000000;
    localparam logic [TEMP_W-1:0] TEMP_ABS_ZERO = 21'h1BD502; // -273150

    // Output status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_READ = 2'd1,
        STATUS_SAT     = 2'd2
    } status_t;

    // Flags that travel with an item through the pipeline.
    typedef struct packed {
        logic                  valid;
        logic                  no_read;
        logic                  full;
        logic                  neg;
        logic                  sat;
        logic [CODE_OUT_W-1:0] code;
    } side_t;

endpackage

>>> design/ntc_log2.sv
module ntc_log2 #(
    parameter int X_W = 10,
    localparam int EXP_W = $clog2(X_W)
) (
    input  logic                                      aclk,
    input  logic                                      en,
    input  logic [X_W-1:0]                            x,
    output logic [EXP_W+ntc_pkg::LOG_FRAC_BITS-1:0]   log_q
);

    localparam int FB = ntc_pkg::LOG_FRAC_BITS;
    localparam int MW = ntc_pkg::MANT_W;

    logic [MW-1:0]    m_reg    [FB+1];
    logic [FB-1:0]    frac_reg [FB+1];
    logic [EXP_W-1:0] e_reg    [FB+1];

    logic [EXP_W-1:0] msb;
    logic [4:0]       shamt;
    logic [MW-1:0]    m_next;

    // Find the leading one and scale the value into [2^30, 2^31).
    always_comb begin
        msb = '0;
        for (int i = 0; i < X_W; i++) begin
            if (x[i]) begin
                msb = EXP_W'(i);
            end
        end
        shamt = 5'(MW - 1) - 5'(msb);
        m_next = MW'(x) << shamt;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0] <= m_next;
            frac_reg[0] <= '0;
            e_reg[0] <= msb;
        end
    end

    // One fraction bit per stage: square the mantissa and renormalize.
    for (genvar k = 1; k <= FB; k++) begin : g_sq
        logic [2*MW-1:0] sq;
        logic [MW:0]     t;
        logic [MW-1:0]   mk_next;
        logic            bit_next;

        assign sq = m_reg[k-1] * m_reg[k-1];
        assign t = sq[2*MW-1:MW-1];
        assign bit_next = t[MW];
        assign mk_next = bit_next ? t[MW:1] : t[MW-1:0];

        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[k] <= mk_next;
                frac_reg[k] <= {frac_reg[k-1][FB-2:0], bit_next};
                e_reg[k] <= e_reg[k-1];
            end
        end
    end

    assign log_q = {e_reg[FB], frac_reg[FB]};

endmodule

>>> design/ntc_div.sv
module ntc_div #(
    parameter int Q_W = 21,
    parameter int DEN_W = 16,
    parameter int TAG_W = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic [Q_W+DEN_W-1:0]   num,
    input  logic [DEN_W-1:0]       den,
    input  logic [TAG_W-1:0]       tag_in,
    output logic [Q_W-1:0]         quo,
    output logic [TAG_W-1:0]       tag_out
);

    // Each stage holds the partial remainder and a shift word that gives up
    // numerator bits at the top and takes quotient bits at the bottom.
    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   sh_reg  [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [TAG_W-1:0] tag_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_prev;
        logic [DEN_W-1:0] den_prev;
        logic [Q_W-1:0]   sh_prev;
        logic [TAG_W-1:0] tag_prev;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [Q_W-1:0]   sh_next;

        if (k == 0) begin : g_first
            assign rem_prev = num[Q_W+DEN_W-1:Q_W];
            assign sh_prev = num[Q_W-1:0];
            assign den_prev = den;
            assign tag_prev = tag_in;
        end else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign sh_prev = sh_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign tag_prev = tag_reg[k-1];
        end

        // Restoring step: one quotient bit.
        assign trial = {rem_prev, sh_prev[Q_W-1]};
        assign diff = trial - {1'b0, den_prev};
        assign ge = trial >= {1'b0, den_prev};
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign sh_next = {sh_prev[Q_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                sh_reg[k] <= sh_next;
                den_reg[k] <= den_prev;
            end
        end

        // The tag carries the valid bit, so it is cleared at reset.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[k] <= '0;
            end else if (en) begin
                tag_reg[k] <= tag_prev;
            end
        end
    end

    assign quo = sh_reg[Q_W-1];
    assign tag_out = tag_reg[Q_W-1];

endmodule

>>> design/thermistor_adc_to_temperature_unit.sv
// NTC thermistor readout from one SPI ADC frame.
// Input channel s_: one item is the three bytes of a received ADC frame.
// Output channel m_: one item per input item with the extracted code, the
// temperature in milli-degrees Celsius, a status code and the command byte
// for the next frame, built from the configuration registers.
// Configuration channel cfg_: register index and data; always ready. Write
// it only while no item is in flight.
// Data passes through the two log2 units, the magnitude, product and rounding
// registers, the beta divider, the inverse and dividend registers, the final
// division and the output register. One item is accepted every cycle unless
// a finished item waits at the output. The nominal inverse temperature is
// recomputed by a free-running 34-stage divider from the registers.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls, the whole pipeline holds; s_tready falls only
// while a finished item waits at the output.
`include "thermistor_adc_to_temperature_unit_macros.svh"

module thermistor_adc_to_temperature_unit #(
    parameter int ADC_BITS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Bits 7:0 rx_first, 15:8 rx_second, 23:16 rx_third.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,
    // Bits 9:0 adc_code, 30:10 temp_milli_c, 32:31 status,
    // 40:33 command_byte, 47:41 zero.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ntc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ntc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int EXP_W = $clog2(ADC_BITS);
    localparam int LOG_W = EXP_W + ntc_pkg::LOG_FRAC_BITS;
    localparam int PROD_W = LOG_W + ntc_pkg::LN2_W;
    localparam int SUM_W = PROD_W + 1;
    localparam int TERM_W = SUM_W - ntc_pkg::ROUND_SHIFT;
    localparam int INV_W = TERM_W + 2;
    localparam int INV_MAG_W = INV_W - 1;
    localparam int TEMP_NUM_W = (TERM_W > 50 ? TERM_W : 50) + 1;
    localparam int WIDE_W = ntc_pkg::TEMP_Q_W + INV_MAG_W;
    localparam int SIDE_W = $bits(ntc_pkg::side_t);

    // Configuration registers.
    logic [ntc_pkg::BETA_W-1:0]        beta_reg;
    logic signed [ntc_pkg::NOM_W-1:0]  nominal_reg;
    logic [ntc_pkg::CHAN_W-1:0]        channel_reg;
    logic                              single_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg <= ntc_pkg::BETA_RESET;
            nominal_reg <= ntc_pkg::NOM_RESET;
            channel_reg <= ntc_pkg::CHAN_RESET;
            single_reg <= ntc_pkg::SINGLE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                ntc_pkg::CFG_BETA: begin
                    beta_reg <= cfg_data;
                end
                ntc_pkg::CFG_NOMINAL: begin
                    nominal_reg <= cfg_data[ntc_pkg::NOM_W-1:0];
                end
                ntc_pkg::CFG_CHANNEL: begin
                    channel_reg <= cfg_data[ntc_pkg::CHAN_W-1:0];
                end
                ntc_pkg::CFG_SINGLE: begin
                    single_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // The pipeline advances unless a finished item waits at the output.
    logic out_valid_reg;
    logic en;
    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Extract the code from the frame.
    logic [23:0]         word;
    logic [ADC_BITS-1:0] code;
    logic [ADC_BITS-1:0] fs_minus_code;
    ntc_pkg::side_t      side_in;

    assign word = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    assign code = ADC_BITS'(word >> 7);
    assign fs_minus_code = {ADC_BITS{1'b1}} - code;

    always_comb begin
        side_in = '0;
        side_in.valid = s_tvalid;
        side_in.no_read = (code == '0);
        side_in.full = (code == {ADC_BITS{1'b1}});
        side_in.code = ntc_pkg::CODE_OUT_W'(code);
    end

    // Logarithms of both divider arms.
    logic [LOG_W-1:0] log_a;
    logic [LOG_W-1:0] log_b;

    ntc_log2 #(.X_W(ADC_BITS)) u_log_a (
        .aclk  (aclk),
        .en    (en),
        .x     (code),
        .log_q (log_a)
    );

    ntc_log2 #(.X_W(ADC_BITS)) u_log_b (
        .aclk  (aclk),
        .en    (en),
        .x     (fs_minus_code),
        .log_q (log_b)
    );

    // Flags follow the log units.
    ntc_pkg::side_t side_log_reg [ntc_pkg::LOG_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ntc_pkg::LOG_LAT; i++) begin
                side_log_reg[i] <= '0;
            end
        end else if (en) begin
            side_log_reg[0] <= side_in;
            for (int i = 1; i < ntc_pkg::LOG_LAT; i++) begin
                side_log_reg[i] <= side_log_reg[i-1];
            end
        end
    end

    // Difference of the logarithms, split into sign and magnitude.
    logic [LOG_W:0]   l2;
    logic             l2_neg;
    logic [LOG_W-1:0] mag_next;
    logic [LOG_W-1:0] mag_reg;
    ntc_pkg::side_t   side_d_reg;
    ntc_pkg::side_t   side_d_next;

    always_comb begin
        l2 = {1'b0, log_a} - {1'b0, log_b};
        l2_neg = l2[LOG_W];
        mag_next = l2_neg ? LOG_W'(-l2) : l2[LOG_W-1:0];
        side_d_next = side_log_reg[ntc_pkg::LOG_LAT-1];
        side_d_next.neg = l2_neg;
    end

    // Scale by ln 2.
    logic [PROD_W-1:0] prod_reg;
    ntc_pkg::side_t    side_m_reg;

    // Round and divide by 2^14 ahead of the beta division.
    logic [ntc_pkg::BETA_W-1:0] beta_eff;
    logic [SUM_W-1:0]           round_sum;
    logic [TERM_W-1:0]          x_reg;
    ntc_pkg::side_t             side_r_reg;

    assign beta_eff = (beta_reg == '0) ? ntc_pkg::BETA_W'(1) : beta_reg;
    assign round_sum = SUM_W'(prod_reg)
        + SUM_W'({beta_eff, (ntc_pkg::ROUND_SHIFT-1)'(0)});

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= mag_next;
            prod_reg <= PROD_W'(mag_reg * ntc_pkg::LN2_Q30);
            x_reg <= round_sum[SUM_W-1:ntc_pkg::ROUND_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_d_reg <= '0;
            side_m_reg <= '0;
            side_r_reg <= '0;
        end else if (en) begin
            side_d_reg <= side_d_next;
            side_m_reg <= side_d_reg;
            side_r_reg <= side_m_reg;
        end
    end

    // Beta term of the inverse temperature.
    logic [TERM_W-1:0] term;
    ntc_pkg::side_t    side_t_out;

    ntc_div #(
        .Q_W   (TERM_W),
        .DEN_W (ntc_pkg::BETA_W),
        .TAG_W (SIDE_W)
    ) u_div_term (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .num     ((TERM_W + ntc_pkg::BETA_W)'(x_reg)),
        .den     (beta_eff),
        .tag_in  (side_r_reg),
        .quo     (term),
        .tag_out (side_t_out)
    );

    // Nominal inverse temperature from the registers, always running.
    logic signed [ntc_pkg::NOM_DEN_W-1:0] nom_ext;
    logic [ntc_pkg::NOM_DEN_W-1:0]        nom_den;
    logic [ntc_pkg::INV0_Q_W-1:0]         inv0;

    assign nom_ext = ntc_pkg::NOM_DEN_W'(nominal_reg);
    assign nom_den = ntc_pkg::NOM_DEN_W'(nom_ext + ntc_pkg::KELVIN_CENTI);

    ntc_div #(
        .Q_W   (ntc_pkg::INV0_Q_W),
        .DEN_W (ntc_pkg::NOM_DEN_W),
        .TAG_W (1)
    ) u_div_inv0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (1'b1),
        .num     (ntc_pkg::INV0_NUMER + ntc_pkg::INV0_NUM_W'(nom_den >> 1)),
        .den     (nom_den),
        .tag_in  (1'b0),
        .quo     (inv0),
        .tag_out ()
    );

    // Combine into 1/T; a nonpositive result saturates.
    logic [INV_W-1:0]     inv_sum;
    logic [INV_MAG_W-1:0] inv_reg;
    ntc_pkg::side_t       side_c_reg;
    ntc_pkg::side_t       side_c_next;

    always_comb begin
        if (side_t_out.neg) begin
            inv_sum = INV_W'(inv0) - INV_W'(term);
        end else begin
            inv_sum = INV_W'(inv0) + INV_W'(term);
        end
        side_c_next = side_t_out;
        if (inv_sum[INV_W-1] || inv_sum == '0) begin
            side_c_next.sat = 1'b1;
        end
    end

    // Dividend of the final division and check that the quotient fits.
    logic [TEMP_NUM_W-1:0] tnum;
    logic                  q_ovf;
    logic [TEMP_NUM_W-1:0] tnum_reg;
    logic [INV_MAG_W-1:0]  tden_reg;
    ntc_pkg::side_t        side_o_reg;
    ntc_pkg::side_t        side_o_next;

    always_comb begin
        tnum = TEMP_NUM_W'(ntc_pkg::TEMP_NUMER) + TEMP_NUM_W'(inv_reg >> 1);
        q_ovf = WIDE_W'(tnum) >= {inv_reg, ntc_pkg::TEMP_Q_W'(0)};
        side_o_next = side_c_reg;
        if (q_ovf) begin
            side_o_next.sat = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inv_reg <= inv_sum[INV_MAG_W-1:0];
            tnum_reg <= tnum;
            tden_reg <= inv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_c_reg <= '0;
            side_o_reg <= '0;
        end else if (en) begin
            side_c_reg <= side_c_next;
            side_o_reg <= side_o_next;
        end
    end

    // Final division gives the temperature in milli-kelvin.
    logic [ntc_pkg::TEMP_Q_W-1:0] q;
    ntc_pkg::side_t               side_q;

    ntc_div #(
        .Q_W   (ntc_pkg::TEMP_Q_W),
        .DEN_W (INV_MAG_W),
        .TAG_W (SIDE_W)
    ) u_div_temp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .num     (WIDE_W'(tnum_reg)),
        .den     (tden_reg),
        .tag_in  (side_o_reg),
        .quo     (q),
        .tag_out (side_q)
    );

    // Special cases, saturation and the output register.
    logic [ntc_pkg::TEMP_W-1:0] temp_next;
    ntc_pkg::status_t           status_next;
    logic [ntc_pkg::CMD_W-1:0]  cmd_next;
    logic [47:0]                tdata_reg;

    always_comb begin
        cmd_next = 8'h80 | {1'b0, single_reg, channel_reg, 3'b000};
        if (side_q.no_read) begin
            temp_next = '0;
            status_next = ntc_pkg::STATUS_NO_READ;
        end else if (side_q.full) begin
            temp_next = ntc_pkg::TEMP_ABS_ZERO;
            status_next = ntc_pkg::STATUS_OK;
        end else if (side_q.sat || q > ntc_pkg::Q_LIMIT) begin
            temp_next = ntc_pkg::TEMP_MAX;
            status_next = ntc_pkg::STATUS_SAT;
        end else begin
            temp_next = q - ntc_pkg::KELVIN_MILLI;
            status_next = ntc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tdata_reg <= {7'd0, cmd_next, status_next, temp_next, side_q.code};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= side_q.valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = tdata_reg;

    `NTC_ASSERT_IMPLY(a_no_read_zero, aclk, aresetn,
        m_tvalid && m_tdata[32:31] == ntc_pkg::STATUS_NO_READ,
        m_tdata[9:0] == '0 && m_tdata[30:10] == '0)
    `NTC_ASSERT_IMPLY(a_sat_max, aclk, aresetn,
        m_tvalid && m_tdata[32:31] == ntc_pkg::STATUS_SAT,
        m_tdata[30:10] == ntc_pkg::TEMP_MAX)
    `NTC_ASSERT_IMPLY(a_empty_ready, aclk, aresetn, !m_tvalid, s_tready)
    `NTC_ASSERT_NEXT(a_drain_empty, aclk, aresetn,
        m_tvalid && m_tready && !side_q.valid, !m_tvalid)

endmodule

>>> tb/sv/ntc_reading_checker.sv
`timescale 1ns / 100ps

// Watches the frame, reading and register channels of the thermistor unit.
// It keeps its own copy of the registers, predicts the reading for each
// accepted frame and compares every returned item with the oldest prediction.
module ntc_reading_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [23:0]                     s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [47:0]                     m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [ntc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ntc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              readings_owed,
    output int                              readings_seen,
    output int                              saturated_seen,
    output int                              no_read_seen
);
    import ntc_pkg::*;

    typedef struct {
        logic [CODE_OUT_W-1:0] code;
        logic [TEMP_W-1:0]     temp;
        status_t               status;
        logic [CMD_W-1:0]      cmd;
    } reading_t;

    reading_t readings_due[$];

    logic [BETA_W-1:0] beta_q;
    logic [NOM_W-1:0]  nominal_q;
    logic [CHAN_W-1:0] channel_q;
    logic              single_q;

    // Base-2 logarithm in Q.24 by repeated squaring of the mantissa.
    function automatic longint unsigned log2_fixed(input longint unsigned x);
        longint unsigned msb;
        longint unsigned mant;
        longint unsigned frac;
        msb = 0;
        frac = 0;
        while (msb < 40 && (x >> (msb + 1)) != 0) msb++;
        mant = (msb <= 30) ? (x << (30 - msb)) : (x >> (msb - 30));
        for (int i = 0; i < LOG_FRAC_BITS; i++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd1 << 31)) begin
                mant = mant >> 1;
                frac = frac | 1;
            end
        end
        return (msb << 24) | frac;
    endfunction

    // Reading for one received frame under the current registers.
    function automatic reading_t predict_reading(input logic [23:0] frame);
        reading_t r;
        longint unsigned code;
        longint l2;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned term;
        longint unsigned dd;
        longint inv0;
        longint inv;
        longint unsigned q;
        longint temp;
        code = {frame[0], frame[15:8], frame[23]};
        temp = 0;
        r.status = STATUS_OK;
        if (code == 0) begin
            r.status = STATUS_NO_READ;
        end else if (code == 1023) begin
            temp = -273150;
        end else begin
            l2 = longint'(log2_fixed(code)) - longint'(log2_fixed(1023 - code));
            mag = longint'(l2 < 0 ? -l2 : l2) * 64'd744261118;
            den = longint'(beta_q == 0 ? 1 : beta_q) << ROUND_SHIFT;
            term = (mag + den / 2) / den;
            dd = longint'($signed(nominal_q)) + 27315;
            inv0 = longint'(((64'd100 << 40) + dd / 2) / dd);
            inv = (l2 < 0) ? inv0 - longint'(term) : inv0 + longint'(term);
            if (inv <= 0) begin
                temp = 1000000;
                r.status = STATUS_SAT;
            end else begin
                q = ((64'd1000 << 40) + longint'(inv) / 2) / longint'(inv);
                if (q > 1273150) begin
                    temp = 1000000;
                    r.status = STATUS_SAT;
                end else begin
                    temp = longint'(q) - 273150;
                end
            end
        end
        r.code = code[9:0];
        r.temp = temp[20:0];
        r.cmd = 8'h80 | (CMD_W'(single_q) << 6) | (CMD_W'(channel_q) << 3);
        return r;
    endfunction

    always @(posedge aclk) begin
        reading_t exp_r;
        reading_t got;
        if (!aresetn) begin
            beta_q <= BETA_RESET;
            nominal_q <= NOM_RESET;
            channel_q <= CHAN_RESET;
            single_q <= SINGLE_RESET;
            fail_count <= 0;
            readings_owed <= 0;
            readings_seen <= 0;
            saturated_seen <= 0;
            no_read_seen <= 0;
            readings_due.delete();
        end else begin
            // Returned item against the oldest prediction.
            if (m_tvalid && m_tready) begin
                got.code = m_tdata[9:0];
                got.temp = m_tdata[30:10];
                got.status = status_t'(m_tdata[32:31]);
                got.cmd = m_tdata[40:33];
                readings_seen <= readings_seen + 1;
                if (readings_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected reading: code %0d temp %0d status %0d cmd %h",
                                 got.code, $signed(got.temp), got.status, got.cmd);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = readings_due.pop_front();
                    if (exp_r.status == STATUS_SAT) saturated_seen <= saturated_seen + 1;
                    if (exp_r.status == STATUS_NO_READ) no_read_seen <= no_read_seen + 1;
                    if (got.code !== exp_r.code || got.temp !== exp_r.temp ||
                        got.status !== exp_r.status || got.cmd !== exp_r.cmd) begin
                        if (fail_count < 10) begin
                            $display("reading mismatch: expected code %0d temp %0d %s",
                                     exp_r.code, $signed(exp_r.temp), "");
                            $display("  expected status %0d cmd %h", exp_r.status,
                                     exp_r.cmd);
                            $display("  got code %0d temp %0d status %0d cmd %h",
                                     got.code, $signed(got.temp), got.status, got.cmd);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // Accepted frame: predict under the registers as they stand.
            if (s_tvalid && s_tready)
                readings_due.push_back(predict_reading(s_tdata));
            readings_owed <= readings_due.size();
            // Register writes; indexes past the last register are ignored.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BETA: beta_q <= cfg_data[BETA_W-1:0];
                    CFG_NOMINAL: nominal_q <= cfg_data[NOM_W-1:0];
                    CFG_CHANNEL: channel_q <= cfg_data[CHAN_W-1:0];
                    CFG_SINGLE: single_q <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import ntc_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 140;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int readings_owed;
    int readings_seen;
    int saturated_seen;
    int no_read_seen;
    int idle_pct = 35;
    int frames_sent = 0;
    int quiet_cycles = 0;
    logic frame_taken = 1'b0;
    logic reg_taken = 1'b0;

    always #5 aclk = ~aclk;

    thermistor_adc_to_temperature_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ntc_reading_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .readings_owed(readings_owed),
        .readings_seen(readings_seen), .saturated_seen(saturated_seen),
        .no_read_seen(no_read_seen)
    );

    // Handshake flags from the edge, read back by the drivers at the falling edge.
    always @(posedge aclk) begin
        frame_taken <= s_tvalid && s_tready;
        reg_taken <= cfg_valid && cfg_ready;
    end

    // Watchdog on cycles in which no item moves on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d readings outstanding", readings_owed);
            $display("thermistor_adc_to_temperature_unit regression: fail");
            $finish;
        end
    end

    // Receiver stalls at random.
    always @(negedge aclk)
        m_tready <= aresetn && ($urandom_range(0, 99) >= idle_pct);

    // Packs a code into a frame, filling the unused bits with noise.
    function automatic logic [23:0] frame_of(input logic [9:0] code);
        logic [31:0] noise;
        noise = $urandom;
        return {code[0], noise[13:7], code[8:1], noise[6:0], code[9]};
    endfunction

    task automatic send_frame(input logic [23:0] frame);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= frame;
        do @(negedge aclk); while (!frame_taken);
        frames_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(negedge aclk); while (!reg_taken);
    endtask

    // Lets every outstanding reading return, then the pipeline settle.
    task automatic drain_readings();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (readings_owed != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic load_regs(input logic [15:0] beta, input logic [14:0] nominal,
                             input logic [2:0] channel, input logic single);
        write_reg(CFG_BETA, beta);
        write_reg(CFG_NOMINAL, {1'b0, nominal});
        write_reg(CFG_CHANNEL, {13'd0, channel});
        write_reg(CFG_SINGLE, {15'd0, single});
        if ($urandom_range(0, 1))
            write_reg(CFG_INDEX_W'($urandom_range(4, 255)), 16'($urandom));
        cfg_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Random codes, with the ends of the range and midscale weighted up.
    function automatic logic [9:0] random_code();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 10'($urandom);
        if (pick < 70) return 10'($urandom_range(0, 3));
        if (pick < 80) return 10'($urandom_range(1020, 1023));
        if (pick < 90) return 10'($urandom_range(500, 523));
        return 10'($urandom_range(0, 40));
    endfunction

    initial begin
        logic [9:0] directed_codes[$];
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed frames under the reset registers.
        directed_codes = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd511, 10'd512, 10'd513,
                           10'd1021, 10'd1022, 10'd1023, 10'h155, 10'h2AA, 10'd100};
        foreach (directed_codes[i]) send_frame(frame_of(directed_codes[i]));
        send_frame(24'h000000);
        send_frame(24'hFFFFFF);
        drain_readings();

        // Register extremes: smallest beta first, then largest beta.
        load_regs(16'd1, 15'($signed(-5000)), 3'd0, 1'b0);
        foreach (directed_codes[i]) send_frame(frame_of(directed_codes[i]));
        drain_readings();
        load_regs(16'd65535, 15'd15000, 3'd7, 1'b1);
        foreach (directed_codes[i]) send_frame(frame_of(directed_codes[i]));
        drain_readings();

        // Random phases; the second one runs with no idling on either side.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: load_regs(16'd0, 15'h4000, 3'($urandom), 1'($urandom));
                1: load_regs(16'($urandom_range(2000, 5000)), 15'($urandom_range(0, 15000)),
                             3'($urandom), 1'($urandom));
                2: load_regs(16'($urandom), 15'($urandom), 3'($urandom), 1'($urandom));
                default: load_regs(16'($urandom_range(1, 200)), 15'h7FFF,
                                   3'($urandom), 1'($urandom));
            endcase
            idle_pct = (phase == 1) ? 0 : 35;
            repeat (165) send_frame(frame_of(random_code()));
            drain_readings();
        end
        idle_pct = 35;

        $display("sent %0d frames over eleven register settings, %0d readings returned",
                 frames_sent, readings_seen);
        $display("%0d saturated and %0d no-reading results among them",
                 saturated_seen, no_read_seen);
        if (fail_count == 0)
            $display("thermistor_adc_to_temperature_unit regression: pass");
        else
            $display("thermistor_adc_to_temperature_unit regression: fail");
        $finish;
    end
endmodule

>>> sim.f
+incdir+design
design/ntc_pkg.sv
design/ntc_log2.sv
design/ntc_div.sv
design/thermistor_adc_to_temperature_unit.sv
tb/sv/ntc_reading_checker.sv
tb/sv/tb.sv
